[rtl/tpd_pkg.sv]
// ----------------------------------------------------------------------------
// tpd_pkg
// shared constants and types of the tile partition derivation unit
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam int MAX_TILES = 32;
  // tile_index is five bits wide, so an axis never holds more than 32 tiles
  localparam int TILE_CAP  = (MAX_TILES < 32) ? MAX_TILES : 32;

  localparam logic [2:0]  CTU_LOG2_MIN = 3'd5;
  localparam logic [13:0] CONS_MAX     = 14'h3FFF;

  // register indexes on the configuration port
  localparam logic [1:0] REG_LOG2_CTU   = 2'd0;
  localparam logic [1:0] REG_PIC_WIDTH  = 2'd1;
  localparam logic [1:0] REG_PIC_HEIGHT = 2'd2;

  // one classified size word on its way from the front to the back
  typedef struct packed {
    logic       ax;
    logic [8:0] size;
    logic       fin;
    logic [8:0] ctus;
  } tpd_item_t;

endpackage

[rtl/tpd_front.sv]
// ----------------------------------------------------------------------------
// tpd_front
// configuration registers and classification of incoming size words
// ----------------------------------------------------------------------------
module tpd_front import tpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_axis,
  input  logic [7:0]  in_size_minus1,
  input  logic        in_last_explicit,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        q_full,
  output logic        q_push,
  output tpd_item_t   q_item
);

  logic [2:0]  log2_ctu_r;
  logic [12:0] pic_width_r;
  logic [12:0] pic_height_r;
  logic [1:0]  reg_idx;
  logic        wr_en;
  logic [2:0]  lg;
  logic [12:0] samples;
  logic [13:0] sum;
  logic [8:0]  ctus;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_ctu_r   <= 3'd5;
      pic_width_r  <= 13'd0;
      pic_height_r <= 13'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LOG2_CTU:   log2_ctu_r   <= pwdata[2:0];
        REG_PIC_WIDTH:  pic_width_r  <= pwdata[12:0];
        REG_PIC_HEIGHT: pic_height_r <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LOG2_CTU:   prdata = {29'd0, log2_ctu_r};
      REG_PIC_WIDTH:  prdata = {19'd0, pic_width_r};
      REG_PIC_HEIGHT: prdata = {19'd0, pic_height_r};
      default:        prdata = 32'd0;
    endcase
  end

  // ceiling shift of the picture size by the ctu size
  assign lg      = (log2_ctu_r < CTU_LOG2_MIN) ? CTU_LOG2_MIN : log2_ctu_r;
  assign samples = in_axis ? pic_height_r : pic_width_r;

  always_comb begin
    unique case (lg)
      3'd6:    sum = {1'b0, samples} + 14'd63;
      3'd7:    sum = {1'b0, samples} + 14'd127;
      default: sum = {1'b0, samples} + 14'd31;
    endcase
    unique case (lg)
      3'd6:    ctus = {1'b0, sum[13:6]} & 9'h1FF;
      3'd7:    ctus = {2'b0, sum[13:7]} & 9'h1FF;
      default: ctus = sum[13:5];
    endcase
  end

  assign in_stall    = q_full;
  assign q_push      = in_valid && !q_full;
  assign q_item.ax   = in_axis;
  assign q_item.size = {1'b0, in_size_minus1} + 9'd1;
  assign q_item.fin  = in_last_explicit;
  assign q_item.ctus = ctus;

endmodule

[rtl/tpd_queue.sv]
// ----------------------------------------------------------------------------
// tpd_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module tpd_queue import tpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tpd_item_t push_item,
  input  logic      pop,
  output tpd_item_t head,
  output logic      empty,
  output logic      full
);

  tpd_item_t  mem_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[rtl/tpd_back.sv]
// ----------------------------------------------------------------------------
// tpd_back
// per-axis tile state, implicit tile sequencer and result register
// ----------------------------------------------------------------------------
module tpd_back import tpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  tpd_item_t  q_head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_axis,
  output logic [4:0] out_tile_index,
  output logic [8:0] out_tile_size,
  output logic       out_is_implicit,
  output logic       out_axis_done,
  output logic [5:0] out_tile_count,
  output logic [8:0] out_ctu_count,
  output logic       out_overflow,
  output logic       out_last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DRY  = 2'd1;
  localparam logic [1:0] S_EXPL = 2'd2;
  localparam logic [1:0] S_IMPL = 2'd3;
  localparam logic [5:0] CAP    = 6'(TILE_CAP);

  logic [1:0]  st_r, st_nxt;
  logic [13:0] consumed_r [2];
  logic [5:0]  tiles_r    [2];
  logic        ovf_seen_r [2];

  logic        cur_ax_r;
  logic [8:0]  cur_size_r;
  logic        cur_fin_r;
  logic [8:0]  cur_ctus_r;
  logic        keep_r;
  logic        impl_en_r;
  logic        ovf_r;
  logic [4:0]  idx_r;
  logic [13:0] d_cons_r;
  logic [5:0]  d_tiles_r;
  logic [8:0]  d_prev_r;
  logic [8:0]  prev_r;

  logic        out_valid_r;
  logic        out_free;
  logic        emit;
  logic        more;

  // pop side
  logic        h_ax;
  logic [13:0] cb;
  logic [5:0]  tb;
  logic        ob;
  logic        keep;
  logic [14:0] cons_sum;
  logic [13:0] cons_sat;

  // implicit step
  logic [13:0] cur_cons;
  logic [5:0]  cur_tiles;
  logic [8:0]  rem;
  logic [8:0]  t_sz;
  logic [13:0] cons_new;
  logic [5:0]  tiles_new;

  // dry run step
  logic [8:0]  d_rem;
  logic [8:0]  d_t;

  assign h_ax     = q_head.ax;
  assign cb       = consumed_r[h_ax];
  assign tb       = tiles_r[h_ax];
  assign ob       = ovf_seen_r[h_ax];
  assign keep     = tb < CAP;
  assign cons_sum = {1'b0, cb} + {6'd0, q_head.size};
  assign cons_sat = cons_sum[14] ? CONS_MAX : cons_sum[13:0];

  assign q_pop    = (st_r == S_IDLE) && !q_empty;
  assign out_free = !out_valid_r || !out_stall;

  assign cur_cons  = consumed_r[cur_ax_r];
  assign cur_tiles = tiles_r[cur_ax_r];
  assign rem       = cur_ctus_r - cur_cons[8:0];
  assign t_sz      = (rem < prev_r) ? rem : prev_r;
  assign cons_new  = cur_cons + {5'd0, t_sz};
  assign tiles_new = cur_tiles + 6'd1;

  assign d_rem = cur_ctus_r - d_cons_r[8:0];
  assign d_t   = (d_rem < d_prev_r) ? d_rem : d_prev_r;

  always_comb begin
    emit = 1'b0;
    more = 1'b0;
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (!q_empty) begin
          priority if (q_head.fin && !ob && keep) st_nxt = S_DRY;
          else if (keep || q_head.fin)            st_nxt = S_EXPL;
          else                                    st_nxt = S_IDLE;
        end
      end
      S_DRY: begin
        if (!(({5'd0, cur_ctus_r} > d_cons_r) && (d_tiles_r < CAP))) st_nxt = S_EXPL;
      end
      S_EXPL: begin
        more = keep_r && impl_en_r && ({5'd0, cur_ctus_r} > cur_cons) && (cur_tiles < CAP);
        if (out_free) begin
          emit   = 1'b1;
          st_nxt = more ? S_IMPL : S_IDLE;
        end
      end
      S_IMPL: begin
        more = ({5'd0, cur_ctus_r} > cons_new) && (tiles_new < CAP);
        if (out_free) begin
          emit   = 1'b1;
          st_nxt = more ? S_IMPL : S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // control and per-axis state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= S_IDLE;
      out_valid_r   <= 1'b0;
      consumed_r[0] <= 14'd0;
      consumed_r[1] <= 14'd0;
      tiles_r[0]    <= 6'd0;
      tiles_r[1]    <= 6'd0;
      ovf_seen_r[0] <= 1'b0;
      ovf_seen_r[1] <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (emit)          out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      if (q_pop) begin
        consumed_r[h_ax] <= cons_sat;
        tiles_r[h_ax]    <= keep ? tb + 6'd1 : tb;
        ovf_seen_r[h_ax] <= ob | !keep;
      end
      // an axis is cleared once its final word has gone out
      if (emit && !more && cur_fin_r) begin
        consumed_r[cur_ax_r] <= 14'd0;
        tiles_r[cur_ax_r]    <= 6'd0;
        ovf_seen_r[cur_ax_r] <= 1'b0;
      end else if (emit && (st_r == S_IMPL)) begin
        consumed_r[cur_ax_r] <= cons_new;
        tiles_r[cur_ax_r]    <= tiles_new;
      end
    end
  end

  // working registers of the current item
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_ax_r   <= h_ax;
      cur_size_r <= q_head.size;
      cur_fin_r  <= q_head.fin;
      cur_ctus_r <= q_head.ctus;
      keep_r     <= keep;
      impl_en_r  <= q_head.fin && !ob;
      ovf_r      <= ob | !keep;
      idx_r      <= tb[4:0];
      d_cons_r   <= cons_sat;
      d_tiles_r  <= keep ? tb + 6'd1 : tb;
      d_prev_r   <= q_head.size;
    end
    if (st_r == S_DRY) begin
      if ({5'd0, cur_ctus_r} > d_cons_r) begin
        if (d_tiles_r < CAP) begin
          d_cons_r  <= d_cons_r + {5'd0, d_t};
          d_tiles_r <= d_tiles_r + 6'd1;
          d_prev_r  <= d_t;
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
    if (st_r == S_EXPL) prev_r <= cur_size_r;
    if (emit && (st_r == S_IMPL)) prev_r <= t_sz;
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_axis      <= cur_ax_r;
      out_ctu_count <= cur_ctus_r;
      out_overflow  <= ovf_r;
      out_last      <= !more;
      out_axis_done <= !more && cur_fin_r;
      out_tile_count <= (!more && cur_fin_r) ? d_tiles_r : 6'd0;
      if (st_r == S_IMPL) begin
        out_tile_index  <= cur_tiles[4:0];
        out_tile_size   <= t_sz;
        out_is_implicit <= 1'b1;
      end else if (keep_r) begin
        out_tile_index  <= idx_r;
        out_tile_size   <= cur_size_r;
        out_is_implicit <= 1'b0;
      end else begin
        out_tile_index  <= 5'd0;
        out_tile_size   <= 9'd0;
        out_is_implicit <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/tile_partition_derivation_unit.sv]
// ----------------------------------------------------------------------------
// tile_partition_derivation_unit
// derives tile column widths and row heights from coded sizes
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  in        input      in_valid / in_stall       in_axis, in_size_minus1, in_last_explicit
//  out       output     out_valid / out_stall     out_axis .. out_last, one word per kept tile or status
//  cfg       input      psel/penable/pwrite/pready  paddr[3:2] selects register
//
//  the front takes a word every cycle into a two-entry queue while the queue is not full
//  a coded size that is not the last of its axis passes the idle and explicit states of the back,
//  and one dropped beyond the tile capacity is popped in idle with no result word
//  a last size that fits takes a dry run for the tile count and the overflow flag that
//  every word carries, then the coded tile and one implicit tile a cycle unless stalled
//  synchronous active-low reset clears the per-axis state and queue, no clearing pass
//  output stall on a valid word holds the result register and the explicit and implicit states
//
module tile_partition_derivation_unit import tpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input word
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_axis,
  input  logic [7:0]  in_size_minus1,
  input  logic        in_last_explicit,
  // result word
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_axis,
  output logic [4:0]  out_tile_index,
  output logic [8:0]  out_tile_size,
  output logic        out_is_implicit,
  output logic        out_axis_done,
  output logic [5:0]  out_tile_count,
  output logic [8:0]  out_ctu_count,
  output logic        out_overflow,
  output logic        out_last,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // queue hand-over
  tpd_item_t push_item;
  tpd_item_t head;
  logic      q_push;
  logic      q_pop;
  logic      q_empty;
  logic      q_full;

  // front: config registers and ctu count per word
  tpd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_axis          (in_axis),
    .in_size_minus1   (in_size_minus1),
    .in_last_explicit (in_last_explicit),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (push_item)
  );

  // decoupling queue
  tpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // back: tile state, implicit tiles, result register
  tpd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_axis        (out_axis),
    .out_tile_index  (out_tile_index),
    .out_tile_size   (out_tile_size),
    .out_is_implicit (out_is_implicit),
    .out_axis_done   (out_axis_done),
    .out_tile_count  (out_tile_count),
    .out_ctu_count   (out_ctu_count),
    .out_overflow    (out_overflow),
    .out_last        (out_last)
  );

endmodule

[tb/tile_partition_derivation_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_partition_derivation_unit_tb
// self-checking bench for the tile column width and row height derivation
// ----------------------------------------------------------------------------
// coded size words go in over the valid/stall channel while a local tile
// predictor derives the expected tile words from the same configuration.
// every result word is checked field by field against the oldest expected
// word. directed runs cover the empty picture, exact fits, implicit fill,
// sizes past the picture, small and large ctu sizes and the tile capacity.
// random runs sweep several picture settings, with gaps on both sides in all
// phases but one; another run holds the result side off long enough for the input to back up.
// ----------------------------------------------------------------------------
module tile_partition_derivation_unit_tb;
  import tpd_pkg::*;

  // one expected or observed result word
  typedef struct packed {
    logic       ax;
    logic [4:0] pos;
    logic [8:0] tsize;
    logic       derived;
    logic       done;
    logic [5:0] count;
    logic [8:0] ctus;
    logic       ovf;
    logic       last;
  } tile_word_t;

  // room for a word still in flight after the last result has left
  localparam int SETTLE_CYCLES = 100;
  // long receiver hold-off so the input side backs up
  localparam int HOLD_CYCLES   = 400;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_axis;
  logic [7:0]  in_size_minus1;
  logic        in_last_explicit;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_axis;
  logic [4:0]  out_tile_index;
  logic [8:0]  out_tile_size;
  logic        out_is_implicit;
  logic        out_axis_done;
  logic [5:0]  out_tile_count;
  logic [8:0]  out_ctu_count;
  logic        out_overflow;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of the registers, reset values as after reset
  logic [2:0]  ctu_log2_cfg = 3'd5;
  logic [12:0] width_cfg    = 13'd0;
  logic [12:0] height_cfg   = 13'd0;

  // predictor copy of the per-axis tile state
  logic [13:0] used_ctus   [2] = '{14'd0, 14'd0};
  logic [5:0]  kept_tiles  [2] = '{6'd0, 6'd0};
  logic        dropped_any [2] = '{1'b0, 1'b0};

  tile_word_t  fresh_tiles[$];   // tiles of the word being predicted
  tile_word_t  tile_q[$];        // expected result words, oldest first

  int  errors        = 0;
  int  words_taken   = 0;
  int  results_seen  = 0;
  int  settings_used = 0;
  bit  tx_gaps       = 1'b1;
  bit  rx_gaps       = 1'b1;
  int  hold_req      = 0;
  int  hold_left     = 0;

  tile_partition_derivation_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_axis          (in_axis),
    .in_size_minus1   (in_size_minus1),
    .in_last_explicit (in_last_explicit),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_axis         (out_axis),
    .out_tile_index   (out_tile_index),
    .out_tile_size    (out_tile_size),
    .out_is_implicit  (out_is_implicit),
    .out_axis_done    (out_axis_done),
    .out_tile_count   (out_tile_count),
    .out_ctu_count    (out_ctu_count),
    .out_overflow     (out_overflow),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // tile predictor
  // ---------------------------------------------------------------------------

  // picture size in ctus along one axis, ceiling shift, ctu sizes below 32 act as 32
  function automatic int ctus_of(logic ax);
    int lg;
    int samples;
    lg = int'(ctu_log2_cfg);
    if (lg < int'(CTU_LOG2_MIN)) lg = int'(CTU_LOG2_MIN);
    samples = ax ? int'(height_cfg) : int'(width_cfg);
    return (samples + (1 << lg) - 1) >> lg;
  endfunction

  // keeps a tile while the axis has room, otherwise marks the axis as overflowed;
  // the ctus count as covered either way
  function automatic void keep_tile(logic ax, int tsize, logic derived, int ctus);
    tile_word_t w;
    int sum;
    if (kept_tiles[ax] < TILE_CAP) begin
      w = '0;
      w.ax = ax;
      w.pos = kept_tiles[ax][4:0];
      w.tsize = tsize[8:0];
      w.derived = derived;
      w.ctus = ctus[8:0];
      fresh_tiles.push_back(w);
      kept_tiles[ax] = kept_tiles[ax] + 6'd1;
    end else begin
      dropped_any[ax] = 1'b1;
    end
    sum = used_ctus[ax] + tsize;
    used_ctus[ax] = (sum > CONS_MAX) ? CONS_MAX : sum[13:0];
  endfunction

  // expected tile words for one accepted size word
  function automatic void derive_tiles(logic ax, logic [7:0] sm1, logic fin);
    tile_word_t w;
    int ctus;
    int prev;
    int rem;
    int t;
    int n;
    ctus = ctus_of(ax);
    prev = sm1 + 1;
    fresh_tiles.delete();
    keep_tile(ax, prev, 1'b0, ctus);
    if (fin) begin
      // fill the rest of the picture, never bigger than the previous tile
      while (used_ctus[ax] < ctus && !dropped_any[ax]) begin
        rem = ctus - used_ctus[ax];
        t = (rem < prev) ? rem : prev;
        keep_tile(ax, t, 1'b1, ctus);
        prev = t;
      end
      // axis full before the last size: a single status word instead
      if (fresh_tiles.size() == 0) begin
        w = '0;
        w.ax = ax;
        w.ctus = ctus[8:0];
        fresh_tiles.push_back(w);
      end
    end
    n = fresh_tiles.size();
    for (int k = 0; k < n; k++) begin
      w = fresh_tiles[k];
      w.ovf = dropped_any[ax];
      if (k == n - 1) begin
        w.last = 1'b1;
        if (fin) begin
          w.done = 1'b1;
          w.count = kept_tiles[ax];
        end
      end
      tile_q.push_back(w);
    end
    if (fin) begin
      used_ctus[ax] = '0;
      kept_tiles[ax] = '0;
      dropped_any[ax] = 1'b0;
    end
  endfunction

  // input monitor: predict at the edge the word is taken
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      derive_tiles(in_axis, in_size_minus1, in_last_explicit);
      words_taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  function automatic void check_field(string what, logic [8:0] want, logic [8:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    tile_word_t got;
    tile_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_axis, out_tile_index, out_tile_size, out_is_implicit, out_axis_done,
             out_tile_count, out_ctu_count, out_overflow, out_last};
      results_seen++;
      if (tile_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, axis %0d index %0d size %0d",
                 $time, got.ax, got.pos, got.tsize);
      end else begin
        want = tile_q.pop_front();
        check_field("axis", want.ax, got.ax);
        check_field("tile_index", want.pos, got.pos);
        check_field("tile_size", want.tsize, got.tsize);
        check_field("is_implicit", want.derived, got.derived);
        check_field("axis_done", want.done, got.done);
        check_field("tile_count", want.count, got.count);
        check_field("ctu_count", want.ctus, got.ctus);
        check_field("overflow", want.ovf, got.ovf);
        check_field("last", want.last, got.last);
      end
    end
  end

  // receiver: random stalls, or a long hold-off counted down here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_req - 1;
      hold_req  <= 0;
    end else begin
      out_stall <= rx_gaps && ($urandom_range(0, 99) < 17);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offers one size word and returns at the edge it is taken;
  // valid stays high into the next word unless a gap is drawn
  task automatic send_word(input logic ax, input logic [7:0] sm1, input logic fin);
    while (tx_gaps && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_axis          <= ax;
    in_size_minus1   <= sm1;
    in_last_explicit <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender pauses until every expected word is back, then lets the block settle
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tile_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup then access cycle; the register takes the value at the access edge
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LOG2_CTU:   ctu_log2_cfg = data[2:0];
      REG_PIC_WIDTH:  width_cfg    = data[12:0];
      REG_PIC_HEIGHT: height_cfg   = data[12:0];
      default: ;
    endcase
  endtask

  task automatic write_config(input logic [2:0] lg, input logic [12:0] w, input logic [12:0] h);
    apb_write(REG_LOG2_CTU, {29'd0, lg});
    apb_write(REG_PIC_WIDTH, {19'd0, w});
    apb_write(REG_PIC_HEIGHT, {19'd0, h});
    settings_used++;
  endtask

  // mostly small sizes so implicit fill happens, now and then any size
  function automatic logic [7:0] pick_size(logic ax);
    int span;
    int r;
    span = ctus_of(ax) / 4;
    if (span < 1) span = 1;
    r = $urandom_range(0, 99);
    if (r < 25) return 8'($urandom_range(0, 255));
    if (r < 55) return 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, span - 1));
  endfunction

  // one well-formed axis: some coded sizes closed by a last size,
  // occasionally long enough to run past the tile capacity
  task automatic send_run();
    logic ax;
    int len;
    ax = 1'($urandom_range(0, 1));
    len = ($urandom_range(0, 99) < 12) ? $urandom_range(30, 35) : $urandom_range(1, 4);
    for (int k = 0; k < len; k++) send_word(ax, pick_size(ax), k == len - 1);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings give a zero sized picture: coded tiles only, no fill
  task automatic test_empty_picture();
    send_word(1'b0, 8'd0, 1'b0);
    send_word(1'b0, 8'd255, 1'b1);
    send_word(1'b1, 8'd17, 1'b1);
    wait_for_results();
  endtask

  // 256 ctus on each axis
  task automatic test_coded_and_derived();
    write_config(3'd5, 13'd8188, 13'd8188);
    // one ctu then fill: runs into the capacity and drops the rest
    send_word(1'b0, 8'd0, 1'b1);
    // a single coded tile covering the whole picture
    send_word(1'b0, 8'd255, 1'b1);
    // two coded rows and a short last one, then fill with that size
    send_word(1'b1, 8'd99, 1'b0);
    send_word(1'b1, 8'd99, 1'b0);
    send_word(1'b1, 8'd9, 1'b1);
    // coded sizes running past the picture, no fill
    send_word(1'b1, 8'd199, 1'b0);
    send_word(1'b1, 8'd199, 1'b0);
    send_word(1'b1, 8'd0, 1'b1);
    send_word(1'b0, 8'd127, 1'b0);
    send_word(1'b0, 8'd200, 1'b1);
    wait_for_results();
  endtask

  // ctu size below the legal range, the largest ctu size and a middle one
  task automatic test_ctu_size();
    write_config(3'd0, 13'd100, 13'd4);
    send_word(1'b0, 8'd0, 1'b1);
    send_word(1'b1, 8'd0, 1'b1);
    send_word(1'b1, 8'd2, 1'b1);
    wait_for_results();
    write_config(3'd7, 13'd8188, 13'd8188);
    send_word(1'b0, 8'd4, 1'b1);
    send_word(1'b1, 8'd255, 1'b1);
    wait_for_results();
    write_config(3'd6, 13'd8188, 13'd100);
    send_word(1'b0, 8'd49, 1'b0);
    send_word(1'b0, 8'd29, 1'b1);
    send_word(1'b1, 8'd0, 1'b1);
    wait_for_results();
  endtask

  // more coded rows than the axis holds: the last size keeps nothing
  task automatic test_capacity();
    write_config(3'd5, 13'd4000, 13'd4000);
    repeat (33) send_word(1'b1, 8'($urandom_range(0, 3)), 1'b0);
    send_word(1'b1, 8'd0, 1'b1);
    wait_for_results();
  endtask

  // receiver holds off while words keep coming, the input must stall
  task automatic test_backpressure();
    logic ax;
    write_config(3'd5, 13'd2048, 13'd8188);
    tx_gaps = 1'b0;
    hold_req <= HOLD_CYCLES;
    repeat (24) begin
      ax = 1'($urandom_range(0, 1));
      send_word(ax, pick_size(ax), $urandom_range(0, 2) == 0);
    end
    tx_gaps = 1'b1;
    wait_for_results();
  endtask

  // random runs over several picture settings, one phase with no gaps at all
  task automatic test_random_runs();
    int target;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_config(3'd5, 13'd8188, 13'd8188);
        1: write_config(3'd7, 13'd0, 13'd8188);
        2: write_config(3'd6, 13'($urandom_range(0, 2047) * 4),
                        13'($urandom_range(0, 2047) * 4));
        default: write_config(3'($urandom_range(0, 7)), 13'($urandom_range(0, 2047) * 4),
                              13'($urandom_range(0, 2047) * 4));
      endcase
      tx_gaps = (phase != 4);
      rx_gaps = (phase != 4);
      target = words_taken + 10;
      while (words_taken < target) begin
        // stray words with random fields now and then
        if ($urandom_range(0, 99) < 10)
          send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        else
          send_run();
      end
      wait_for_results();
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_axis          <= 1'b0;
    in_size_minus1   <= 8'd0;
    in_last_explicit <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= 4'd0;
    pwdata           <= 32'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_picture();
    test_coded_and_derived();
    test_ctu_size();
    test_capacity();
    test_backpressure();
    test_random_runs();

    $display("covered %0d size words and %0d tile words over %0d picture settings",
             words_taken, results_seen, settings_used);
    $display("incl. empty picture, fill, capacity drop, ctu size clamp and a long hold-off");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

  // hard limit on the run
  initial begin
    #10_000_000;
    $display("timeout, %0d tile words still expected", tile_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

[sim.f]
rtl/tpd_pkg.sv
rtl/tpd_front.sv
rtl/tpd_queue.sv
rtl/tpd_back.sv
rtl/tile_partition_derivation_unit.sv
tb/tile_partition_derivation_unit_tb.sv
